/* rtl/umcd_pkg.sv */
// ----------------------------------------------------------------------------
// umcd_pkg
// Shared types and codes for the configuration descriptor parser.
// ----------------------------------------------------------------------------
package umcd_pkg;

  localparam int BYTE_W    = 8;
  localparam int EP_NUM_W  = 4;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_SIZE_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NO_IFACE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WANT_CLASS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WANT_SUBCLASS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WANT_PROTOCOL = 2'd2;

  localparam logic [BYTE_W-1:0] RST_WANT_CLASS    = 8'd8;
  localparam logic [BYTE_W-1:0] RST_WANT_SUBCLASS = 8'd6;
  localparam logic [BYTE_W-1:0] RST_WANT_PROTOCOL = 8'd80;

  // descriptor types
  localparam logic [BYTE_W-1:0] DT_INTERFACE = 8'd4;
  localparam logic [BYTE_W-1:0] DT_ENDPOINT  = 8'd5;

  // byte offsets within a descriptor
  localparam logic [BYTE_W-1:0] OFS_LENGTH   = 8'd0;
  localparam logic [BYTE_W-1:0] OFS_TYPE     = 8'd1;
  localparam logic [BYTE_W-1:0] OFS_EP_ADDR  = 8'd2;
  localparam logic [BYTE_W-1:0] OFS_EP_ATTR  = 8'd3;
  localparam logic [BYTE_W-1:0] OFS_EP_SIZE  = 8'd4;
  localparam logic [BYTE_W-1:0] OFS_IF_CLASS = 8'd5;
  localparam logic [BYTE_W-1:0] OFS_IF_SUB   = 8'd6;
  localparam logic [BYTE_W-1:0] OFS_IF_PROTO = 8'd7;

  localparam logic [BYTE_W-1:0] ATTR_XFER_MASK = 8'h03;
  localparam logic [BYTE_W-1:0] ATTR_BULK      = 8'd2;
  localparam int                EP_DIR_BIT     = 7;

  typedef struct packed {
    logic [BYTE_W-1:0] want_class;
    logic [BYTE_W-1:0] want_subclass;
    logic [BYTE_W-1:0] want_protocol;
  } cfg_t;

  typedef struct packed {
    logic                found;
    logic [EP_NUM_W-1:0] number;
    logic [BYTE_W-1:0]   size;
  } ep_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    ep_t                 ep_in;
    ep_t                 ep_out;
  } result_t;

endpackage

/* rtl/umcd_if.sv */
// ----------------------------------------------------------------------------
// umcd channel interfaces
// Byte input, result output and register write channels.
// ----------------------------------------------------------------------------
interface umcd_in_if;
  logic                       valid;
  logic                       ready;
  logic [umcd_pkg::BYTE_W-1:0] data_byte;
  logic                       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface umcd_out_if;
  logic                          valid;
  logic                          ready;
  logic [umcd_pkg::STATUS_W-1:0] status;
  logic                          in_found;
  logic [umcd_pkg::EP_NUM_W-1:0] in_ep_number;
  logic [umcd_pkg::BYTE_W-1:0]   in_packet_size;
  logic                          out_found;
  logic [umcd_pkg::EP_NUM_W-1:0] out_ep_number;
  logic [umcd_pkg::BYTE_W-1:0]   out_packet_size;

  modport source (output valid, status, in_found, in_ep_number, in_packet_size,
                  out_found, out_ep_number, out_packet_size, input ready);
  modport sink   (input valid, status, in_found, in_ep_number, in_packet_size,
                  out_found, out_ep_number, out_packet_size, output ready);
endinterface

interface umcd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [umcd_pkg::CFG_IDX_W-1:0] index;
  logic [umcd_pkg::BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/umcd_parser.sv */
// ----------------------------------------------------------------------------
// umcd_parser
// Per-byte descriptor walk: tracks offset and length, matches interfaces,
// records bulk endpoints and forms the result on the last byte.
// ----------------------------------------------------------------------------
module umcd_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [umcd_pkg::BYTE_W-1:0] data_byte,
  input  logic                        last_byte,
  input  umcd_pkg::cfg_t              cfg,
  output umcd_pkg::result_t           res_nxt
);

  localparam int W = umcd_pkg::BYTE_W;

  logic [W-1:0]   offset_r, offset_nxt;
  logic [W-1:0]   len_r, len_nxt;
  logic [W-1:0]   type_r, type_nxt;
  logic [W-1:0]   hold0_r, hold0_nxt;
  logic [W-1:0]   hold1_r, hold1_nxt;
  logic           good_r, good_nxt;
  logic           err_r, err_nxt;
  umcd_pkg::ep_t  ep_in_r, ep_in_nxt;
  umcd_pkg::ep_t  ep_out_r, ep_out_nxt;
  logic [W-1:0]   len_eff;
  logic [W:0]     offset_inc;
  logic           err_fin;
  umcd_pkg::ep_t  ep_new;

  always_comb begin
    offset_nxt = offset_r;
    len_nxt    = len_r;
    type_nxt   = type_r;
    hold0_nxt  = hold0_r;
    hold1_nxt  = hold1_r;
    good_nxt   = good_r;
    err_nxt    = err_r;
    ep_in_nxt  = ep_in_r;
    ep_out_nxt = ep_out_r;
    len_eff    = (offset_r == umcd_pkg::OFS_LENGTH) ? data_byte : len_r;
    offset_inc = {1'b0, offset_r} + {{W{1'b0}}, 1'b1};
    ep_new.found  = 1'b1;
    ep_new.number = hold0_r[umcd_pkg::EP_NUM_W-1:0];
    ep_new.size   = data_byte;

    if (!err_r) begin
      if (offset_r == umcd_pkg::OFS_LENGTH) begin
        len_nxt  = data_byte;
        type_nxt = '0;
        if (data_byte == '0) begin
          err_nxt = 1'b1;
        end
      end else if (offset_r == umcd_pkg::OFS_TYPE) begin
        type_nxt = data_byte;
        if (data_byte == umcd_pkg::DT_INTERFACE) begin
          good_nxt = 1'b0;
        end
      end else if (type_r == umcd_pkg::DT_INTERFACE) begin
        if (offset_r == umcd_pkg::OFS_IF_CLASS) begin
          hold0_nxt = data_byte;
        end else if (offset_r == umcd_pkg::OFS_IF_SUB) begin
          hold1_nxt = data_byte;
        end else if (offset_r == umcd_pkg::OFS_IF_PROTO) begin
          good_nxt = (hold0_r == cfg.want_class) && (hold1_r == cfg.want_subclass) &&
                     (data_byte == cfg.want_protocol);
        end
      end else if (type_r == umcd_pkg::DT_ENDPOINT) begin
        if (offset_r == umcd_pkg::OFS_EP_ADDR) begin
          hold0_nxt = data_byte;
        end else if (offset_r == umcd_pkg::OFS_EP_ATTR) begin
          hold1_nxt = data_byte;
        end else if (offset_r == umcd_pkg::OFS_EP_SIZE) begin
          if (good_r && ((hold1_r & umcd_pkg::ATTR_XFER_MASK) == umcd_pkg::ATTR_BULK)) begin
            if (hold0_r[umcd_pkg::EP_DIR_BIT]) begin
              ep_in_nxt = ep_new;
            end else begin
              ep_out_nxt = ep_new;
            end
          end
        end
      end
      // a zero length byte leaves the offset where it is
      if (!err_nxt) begin
        if (offset_inc >= {1'b0, len_eff}) begin
          offset_nxt = '0;
        end else begin
          offset_nxt = offset_inc[W-1:0];
        end
      end
    end

    // descriptor still open at the end of the set is an overrun
    err_fin = err_nxt || (offset_nxt != '0);
    res_nxt.status = err_fin ? umcd_pkg::STAT_SIZE_ERR :
                     (good_nxt ? umcd_pkg::STAT_OK : umcd_pkg::STAT_NO_IFACE);
    res_nxt.ep_in  = ep_in_nxt;
    res_nxt.ep_out = ep_out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last_byte)) begin
      offset_r <= '0;
      len_r    <= '0;
      type_r   <= '0;
      hold0_r  <= '0;
      hold1_r  <= '0;
      good_r   <= 1'b0;
      err_r    <= 1'b0;
      ep_in_r  <= '0;
      ep_out_r <= '0;
    end else if (take) begin
      offset_r <= offset_nxt;
      len_r    <= len_nxt;
      type_r   <= type_nxt;
      hold0_r  <= hold0_nxt;
      hold1_r  <= hold1_nxt;
      good_r   <= good_nxt;
      err_r    <= err_nxt;
      ep_in_r  <= ep_in_nxt;
      ep_out_r <= ep_out_nxt;
    end
  end

endmodule

/* rtl/usb_msc_config_descriptor_parser.sv */
// ----------------------------------------------------------------------------
// usb_msc_config_descriptor_parser
// Walks a configuration descriptor set byte by byte and reports the bulk
// endpoints of the matching mass-storage interface on the last byte.
//
//   channel   dir  beat
//   in_bus    in   data_byte, last_byte
//   out_bus   out  status, IN endpoint, OUT endpoint (one beat per set)
//   cfg_bus   in   index, data (want_class, want_subclass, want_protocol)
//
// One byte per cycle; the parse state updates in the cycle a byte is taken.
// The result is registered in the output register when the last byte is taken.
// in_bus stalls only while a result waits in the output register and
// out_bus.ready is low. cfg_bus is always ready.
// Synchronous active-low reset clears parse state and loads register defaults.
// ----------------------------------------------------------------------------
module usb_msc_config_descriptor_parser (
  input  logic       clk,
  input  logic       rst_n,
  umcd_in_if.sink    in_bus,
  umcd_out_if.source out_bus,
  umcd_cfg_if.sink   cfg_bus
);

  umcd_pkg::cfg_t    cfg_r;
  umcd_pkg::result_t res_nxt;
  umcd_pkg::result_t res_r;
  logic              out_valid_r;
  logic              take;

  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign take          = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.want_class    <= umcd_pkg::RST_WANT_CLASS;
      cfg_r.want_subclass <= umcd_pkg::RST_WANT_SUBCLASS;
      cfg_r.want_protocol <= umcd_pkg::RST_WANT_PROTOCOL;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        umcd_pkg::REG_WANT_CLASS:    cfg_r.want_class    <= cfg_bus.data;
        umcd_pkg::REG_WANT_SUBCLASS: cfg_r.want_subclass <= cfg_bus.data;
        umcd_pkg::REG_WANT_PROTOCOL: cfg_r.want_protocol <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  umcd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_bus.data_byte),
    .last_byte (in_bus.last_byte),
    .cfg       (cfg_r),
    .res_nxt   (res_nxt)
  );

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && in_bus.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_bus.last_byte) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.status          = res_r.status;
  assign out_bus.in_found        = res_r.ep_in.found;
  assign out_bus.in_ep_number    = res_r.ep_in.number;
  assign out_bus.in_packet_size  = res_r.ep_in.size;
  assign out_bus.out_found       = res_r.ep_out.found;
  assign out_bus.out_ep_number   = res_r.ep_out.number;
  assign out_bus.out_packet_size = res_r.ep_out.size;

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(take && out_valid_r && !out_bus.ready))
    else $error("byte taken while result stalled");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take && in_bus.last_byte))
    else $error("result without a last byte");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.status == umcd_pkg::STAT_OK ||
                     res_r.status == umcd_pkg::STAT_SIZE_ERR ||
                     res_r.status == umcd_pkg::STAT_NO_IFACE))
    else $error("status code out of range");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds configuration descriptor sets to the parser one byte per beat and
// checks every result beat against an in-bench parse of the same bytes.
// A short stimulus table with hand-written results comes first. Random sets
// follow in four phases of sender and receiver stall settings, each phase under
// its own class/subclass/protocol setting.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BW          = umcd_pkg::BYTE_W;

  typedef struct {
    logic [BW-1:0]     data;
    logic              last;
    bit                typed;
    umcd_pkg::result_t want;
  } stim_row_t;

  localparam umcd_pkg::ep_t     EP_NONE   = '0;
  localparam umcd_pkg::result_t NO_RESULT = '0;

  logic clk;
  logic rst_n;

  umcd_in_if  in_bus ();
  umcd_out_if out_bus ();
  umcd_cfg_if cfg_bus ();

  usb_msc_config_descriptor_parser u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // parse state mirrored by the bench
  umcd_pkg::cfg_t    p_cfg;
  logic [BW-1:0]     p_offset;
  logic [BW-1:0]     p_dlen;
  logic [BW-1:0]     p_dtype;
  logic [BW-1:0]     p_hold [2];
  logic              p_good;
  logic              p_len_err;
  umcd_pkg::ep_t     p_ep_in;
  umcd_pkg::ep_t     p_ep_out;

  umcd_pkg::result_t pending_reports [$];
  logic [BW-1:0]     set_bytes [$];
  stim_row_t         dir_tab [26];
  int                fail_count;
  int                send_gap_pct;
  int                recv_stall_pct;
  int                cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [BW-1:0] rand_byte(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(hi, lo);
    return r[BW-1:0];
  endfunction

  task automatic clear_parse();
    p_offset  = '0;
    p_dlen    = '0;
    p_dtype   = '0;
    p_hold[0] = '0;
    p_hold[1] = '0;
    p_good    = 1'b0;
    p_len_err = 1'b0;
    p_ep_in   = EP_NONE;
    p_ep_out  = EP_NONE;
  endtask

  // advance the mirrored parse by one byte; done is set on the last byte
  task automatic parse_byte(input logic [BW-1:0] b, input logic last,
                            output bit done, output umcd_pkg::result_t rpt);
    umcd_pkg::ep_t ep;
    done = 1'b0;
    rpt  = NO_RESULT;
    if (!p_len_err) begin
      if (p_offset == umcd_pkg::OFS_LENGTH) begin
        p_dlen  = b;
        p_dtype = '0;
        if (b == '0) p_len_err = 1'b1;
      end else if (p_offset == umcd_pkg::OFS_TYPE) begin
        p_dtype = b;
        if (b == umcd_pkg::DT_INTERFACE) p_good = 1'b0;
      end else if (p_dtype == umcd_pkg::DT_INTERFACE) begin
        if (p_offset == umcd_pkg::OFS_IF_CLASS) p_hold[0] = b;
        else if (p_offset == umcd_pkg::OFS_IF_SUB) p_hold[1] = b;
        else if (p_offset == umcd_pkg::OFS_IF_PROTO)
          p_good = (p_hold[0] == p_cfg.want_class) &&
                   (p_hold[1] == p_cfg.want_subclass) &&
                   (b == p_cfg.want_protocol);
      end else if (p_dtype == umcd_pkg::DT_ENDPOINT) begin
        if (p_offset == umcd_pkg::OFS_EP_ADDR) p_hold[0] = b;
        else if (p_offset == umcd_pkg::OFS_EP_ATTR) p_hold[1] = b;
        else if (p_offset == umcd_pkg::OFS_EP_SIZE) begin
          if (p_good && (p_hold[1] & umcd_pkg::ATTR_XFER_MASK) == umcd_pkg::ATTR_BULK) begin
            ep.found  = 1'b1;
            ep.number = p_hold[0][umcd_pkg::EP_NUM_W-1:0];
            ep.size   = b;
            if (p_hold[0][umcd_pkg::EP_DIR_BIT]) p_ep_in = ep;
            else p_ep_out = ep;
          end
        end
      end
      // a zero length byte freezes the offset
      if (!p_len_err) begin
        if ({1'b0, p_offset} + 9'd1 >= {1'b0, p_dlen}) p_offset = '0;
        else p_offset = p_offset + 8'd1;
      end
    end
    if (last) begin
      if (p_offset != '0) p_len_err = 1'b1;
      rpt.status = p_len_err ? umcd_pkg::STAT_SIZE_ERR :
                   (p_good ? umcd_pkg::STAT_OK : umcd_pkg::STAT_NO_IFACE);
      rpt.ep_in  = p_ep_in;
      rpt.ep_out = p_ep_out;
      done = 1'b1;
      clear_parse();
    end
  endtask

  // present one beat, hold it until taken, then update the prediction
  task automatic send_byte(input logic [BW-1:0] b, input logic last,
                           input bit typed, input umcd_pkg::result_t want);
    bit                done;
    umcd_pkg::result_t rpt;
    while ($urandom_range(99) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    parse_byte(b, last, done, rpt);
    if (done) pending_reports.push_back(typed ? want : rpt);
  endtask

  // drop valid and wait for every pending result plus the output latency
  task automatic wait_quiet();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [umcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [BW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      umcd_pkg::REG_WANT_CLASS:    p_cfg.want_class    = val;
      umcd_pkg::REG_WANT_SUBCLASS: p_cfg.want_subclass = val;
      umcd_pkg::REG_WANT_PROTOCOL: p_cfg.want_protocol = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [BW-1:0] cls, input logic [BW-1:0] sub,
                            input logic [BW-1:0] pro);
    write_reg(umcd_pkg::REG_WANT_CLASS, cls);
    write_reg(umcd_pkg::REG_WANT_SUBCLASS, sub);
    write_reg(umcd_pkg::REG_WANT_PROTOCOL, pro);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic fill_desc(ref logic [BW-1:0] d [$], input int len,
                           input logic [BW-1:0] dtype);
    d.delete();
    d.push_back(len[BW-1:0]);
    if (len > 1) d.push_back(dtype);
    while (d.size() < len) d.push_back(rand_byte(0, 255));
  endtask

  // mostly well-formed sets aimed at the current setting, some broken
  task automatic build_set();
    int            ndesc;
    int            kind;
    int            len;
    int            cut;
    logic [BW-1:0] cls;
    logic [BW-1:0] sub;
    logic [BW-1:0] pro;
    logic [BW-1:0] attr;
    logic [BW-1:0] d [$];
    set_bytes.delete();
    ndesc = $urandom_range(4, 1);
    for (int k = 0; k < ndesc; k++) begin
      kind = (k == 0 && $urandom_range(99) < 60) ? 0 : $urandom_range(99);
      d.delete();
      if (kind < 30) begin
        case ($urandom_range(9))
          0:       len = $urandom_range(7, 2);
          1:       len = $urandom_range(12, 8);
          default: len = 9;
        endcase
        fill_desc(d, len, umcd_pkg::DT_INTERFACE);
        cls = p_cfg.want_class;
        sub = p_cfg.want_subclass;
        pro = p_cfg.want_protocol;
        if ($urandom_range(99) >= 70) begin
          case ($urandom_range(2))
            0:       cls = rand_byte(0, 255);
            1:       sub = rand_byte(0, 255);
            default: pro = rand_byte(0, 255);
          endcase
        end
        if (len > 5) d[5] = cls;
        if (len > 6) d[6] = sub;
        if (len > 7) d[7] = pro;
      end else if (kind < 65) begin
        case ($urandom_range(9))
          0:       len = $urandom_range(4, 2);
          1:       len = $urandom_range(6, 5);
          2:       len = $urandom_range(10, 8);
          default: len = 7;
        endcase
        fill_desc(d, len, umcd_pkg::DT_ENDPOINT);
        attr = rand_byte(0, 255);
        if ($urandom_range(99) < 75) attr[1:0] = umcd_pkg::ATTR_BULK[1:0];
        if (len > 3) d[3] = attr;
      end else if (kind < 80) begin
        fill_desc(d, $urandom_range(12, 2), rand_byte(0, 255));
      end else if (kind < 85) begin
        d.push_back(8'd1);
      end else if (kind < 90) begin
        // zero length, then bytes that are ignored
        d.push_back(8'd0);
        repeat ($urandom_range(4)) d.push_back(rand_byte(0, 255));
      end else begin
        // length far beyond what follows
        d.push_back(rand_byte(13, 255));
        repeat ($urandom_range(5, 1)) d.push_back(rand_byte(0, 255));
      end
      set_bytes = {set_bytes, d};
    end
    if (set_bytes.size() > 1 && $urandom_range(99) < 10) begin
      cut = $urandom_range(set_bytes.size() - 1, 1);
      repeat (cut) void'(set_bytes.pop_back());
    end
  endtask

  task automatic cmp_field(input string name, input logic [BW-1:0] want_v,
                           input logic [BW-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  task automatic check_report(input umcd_pkg::result_t got);
    umcd_pkg::result_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t: result %h with nothing pending", $time, got);
      fail_count++;
    end else begin
      want = pending_reports.pop_front();
      cmp_field("status", BW'(want.status), BW'(got.status));
      cmp_field("in_found", BW'(want.ep_in.found), BW'(got.ep_in.found));
      cmp_field("in_ep_number", BW'(want.ep_in.number), BW'(got.ep_in.number));
      cmp_field("in_packet_size", want.ep_in.size, got.ep_in.size);
      cmp_field("out_found", BW'(want.ep_out.found), BW'(got.ep_out.found));
      cmp_field("out_ep_number", BW'(want.ep_out.number), BW'(got.ep_out.number));
      cmp_field("out_packet_size", want.ep_out.size, got.ep_out.size);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready)
      check_report({out_bus.status, out_bus.in_found, out_bus.in_ep_number,
                    out_bus.in_packet_size, out_bus.out_found, out_bus.out_ep_number,
                    out_bus.out_packet_size});
    out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("usb_msc_config_descriptor_parser: mismatch");
    $finish;
  end

  initial begin
    int sets_done;
    int bytes_done;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last_byte = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    fail_count       = 0;
    send_gap_pct     = 0;
    recv_stall_pct   = 0;
    p_cfg            = '{umcd_pkg::RST_WANT_CLASS, umcd_pkg::RST_WANT_SUBCLASS,
                         umcd_pkg::RST_WANT_PROTOCOL};
    clear_parse();

    dir_tab = '{
      // zero length byte straight after reset
      '{8'h00, 1'b1, 1'b1, '{umcd_pkg::STAT_SIZE_ERR, EP_NONE, EP_NONE}},
      // largest length, set ends after one byte
      '{8'hFF, 1'b1, 1'b1, '{umcd_pkg::STAT_SIZE_ERR, EP_NONE, EP_NONE}},
      // length one has no type byte
      '{8'h01, 1'b1, 1'b1, '{umcd_pkg::STAT_NO_IFACE, EP_NONE, EP_NONE}},
      // mass-storage interface at the default setting
      '{8'h09, 1'b0, 1'b0, NO_RESULT}, '{8'h04, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h02, 1'b0, 1'b0, NO_RESULT}, '{8'h08, 1'b0, 1'b0, NO_RESULT},
      '{8'h06, 1'b0, 1'b0, NO_RESULT}, '{8'h50, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      // bulk IN, endpoint 15, size low byte 0xFF
      '{8'h07, 1'b0, 1'b0, NO_RESULT}, '{8'h05, 1'b0, 1'b0, NO_RESULT},
      '{8'h8F, 1'b0, 1'b0, NO_RESULT}, '{8'h02, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT}, '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      // bulk OUT, endpoint 0, size low byte 0x00
      '{8'h07, 1'b0, 1'b0, NO_RESULT}, '{8'h05, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h02, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT}, '{8'h02, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, 1'b1,
        '{umcd_pkg::STAT_OK, '{1'b1, 4'hF, 8'hFF}, '{1'b1, 4'h0, 8'h00}}}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      wait_quiet();
      case (ph)
        0: begin
          send_gap_pct = 0;  recv_stall_pct = 0;
          set_config(8'h00, 8'h00, 8'h00);
        end
        1: begin
          send_gap_pct = 75; recv_stall_pct = 0;
          set_config(8'hFF, 8'hFF, 8'hFF);
        end
        2: begin
          send_gap_pct = 0;  recv_stall_pct = 75;
          set_config(rand_byte(0, 255), rand_byte(0, 255), rand_byte(0, 255));
        end
        default: begin
          send_gap_pct = 24; recv_stall_pct = 24;
          set_config(umcd_pkg::RST_WANT_CLASS, umcd_pkg::RST_WANT_SUBCLASS,
                     umcd_pkg::RST_WANT_PROTOCOL);
        end
      endcase
      sets_done  = 0;
      bytes_done = 0;
      while (bytes_done < 106 || sets_done < 4) begin
        // hold the sender until the block has drained
        if (sets_done == 3) wait_quiet();
        build_set();
        foreach (set_bytes[i])
          send_byte(set_bytes[i], i == set_bytes.size() - 1, 1'b0, NO_RESULT);
        bytes_done += set_bytes.size();
        sets_done++;
      end
    end

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("usb_msc_config_descriptor_parser: match");
    end else begin
      $display("usb_msc_config_descriptor_parser: mismatch");
    end
    $finish;
  end

endmodule
